@@ hdl/vts_pkg.sv @@
`default_nettype none

package vts_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOC,
    ST_OFFS,
    ST_BASE,
    ST_READ,
    ST_MUL,
    ST_ADD
  } state_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  localparam logic [1:0] REG_POINTS_X = 2'd0;
  localparam logic [1:0] REG_POINTS_Y = 2'd1;
  localparam logic [1:0] REG_POINTS_Z = 2'd2;

  localparam logic [5:0]  POINTS_RESET = 6'd32;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam int          FRAC_BITS    = 16;
  localparam int          HALF_Q16     = 32768;

endpackage

`default_nettype wire

@@ hdl/volume_trilinear_sampler_top.sv @@
// A write or an out-of-range sample returns its result strobe in the cycle after accept.
// An in-range sample runs from accept to result transfer through 3 cell
//   locate steps, 2 address steps, the 8 corner reads of the single-port
//   grid memory, and 7 blends (multiply, then add) through one shared multiplier.
// Throughput: one sample at a time; writes and out-of-range samples one per cycle when idle.
// Reset: clears control state and sets every point count to 32; the grid memory is not cleared.
`default_nettype none

module volume_trilinear_sampler_top #(
  parameter int MAX_POINTS  = 32,
  parameter int GRID_DEPTH  = 32768,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [14:0] sample_address_i,
  input  wire logic [15:0] sample_value_i,
  input  wire logic [16:0] pos_x_i,
  input  wire logic [16:0] pos_y_i,
  input  wire logic [16:0] pos_z_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  output logic             done_o,
  output logic [15:0]      interpolated_value_o,
  output logic             pos_err_o
);

  localparam int PW  = $clog2(MAX_POINTS + 1);
  localparam int LW  = 3 * PW;
  localparam int IW  = $clog2(GRID_DEPTH);
  localparam int SW  = 17 + PW;
  localparam int SB  = SAMPLE_BITS;
  localparam int PRW = SB + 19;

  vts_pkg::state_e state_q, state_d;

  logic [5:0] pts_q [3];
  logic [PW-1:0] np [3];

  logic [16:0] pos_q [3];
  logic [PW-1:0] cell_q [3];
  logic [16:0] frac_q [3];
  logic [1:0] axis_q;

  logic [2*PW-1:0] nxny_q;
  logic [LW-1:0] yoff_q, zoff_q, base_q;

  logic [3:0] k_q;
  logic [3:0] n_q;
  logic [SB-1:0] v_q [8];
  logic [SB-1:0] a_q;
  logic signed [PRW-1:0] prod_q;

  logic [SB-1:0] mem_q [GRID_DEPTH];
  logic [SB-1:0] rdata_q;
  logic rd_oob_q;

  logic done_q, oor_q;
  logic [15:0] value_q;

  logic accept;
  logic pos_bad;
  logic [16:0] pos_sel;
  logic [PW-1:0] cells_sel;
  logic [SW-1:0] scaled;
  logic [PW:0] c_raw;
  logic [PW-1:0] c_clamp;
  logic [LW-1:0] corner_addr;
  logic corner_ok;
  logic wr_ok;
  logic mem_we;
  logic [IW-1:0] mem_idx;
  logic [16:0] f_sel;
  logic signed [SB:0] diff;
  logic signed [PRW-1:0] rnd;
  logic [SB-1:0] blend_r;
  logic [3:0] n_m2;
  logic [2:0] ins_idx;

  assign busy_o = (state_q != vts_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;
  assign pos_bad = (pos_x_i > vts_pkg::ONE_Q16) || (pos_y_i > vts_pkg::ONE_Q16) ||
                   (pos_z_i > vts_pkg::ONE_Q16);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pts_q[i] < 6'd2) begin
        np[i] = PW'(2);
      end else if (32'(pts_q[i]) > MAX_POINTS) begin
        np[i] = PW'(MAX_POINTS);
      end else begin
        np[i] = PW'(pts_q[i]);
      end
    end
  end

  // cell locate, one axis per cycle
  always_comb begin
    pos_sel   = pos_q[axis_q];
    cells_sel = np[axis_q] - PW'(1);
    scaled    = SW'(pos_sel) * SW'(cells_sel);
    c_raw     = scaled[SW-1:vts_pkg::FRAC_BITS];
    if (c_raw > (PW+1)'(cells_sel - PW'(1))) begin
      c_clamp = cells_sel - PW'(1);
    end else begin
      c_clamp = PW'(c_raw);
    end
  end

  always_comb begin
    corner_addr = base_q + (k_q[0] ? LW'(1) : '0) + (k_q[1] ? LW'(np[0]) : '0) +
                  (k_q[2] ? LW'(nxny_q) : '0);
    corner_ok   = (32'(corner_addr) < GRID_DEPTH);
    wr_ok       = (32'(sample_address_i) < GRID_DEPTH);
    mem_we      = accept && (operation_i == vts_pkg::OP_WRITE) && wr_ok;
    mem_idx     = busy_o ? IW'(corner_addr) : IW'(sample_address_i);
  end

  always_comb begin
    if (n_q >= 4'd5) begin
      f_sel = frac_q[0];
    end else if (n_q >= 4'd3) begin
      f_sel = frac_q[1];
    end else begin
      f_sel = frac_q[2];
    end
    diff    = $signed({1'b0, v_q[1]}) - $signed({1'b0, v_q[0]});
    rnd     = (prod_q + PRW'(vts_pkg::HALF_Q16)) >>> vts_pkg::FRAC_BITS;
    blend_r = a_q + SB'(rnd);
    n_m2    = n_q - 4'd2;
    ins_idx = n_m2[2:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      vts_pkg::ST_IDLE: begin
        if (accept && (operation_i == vts_pkg::OP_SAMPLE) && !pos_bad) begin
          state_d = vts_pkg::ST_LOC;
        end
      end
      vts_pkg::ST_LOC: begin
        if (axis_q == 2'd2) begin
          state_d = vts_pkg::ST_OFFS;
        end
      end
      vts_pkg::ST_OFFS: state_d = vts_pkg::ST_BASE;
      vts_pkg::ST_BASE: state_d = vts_pkg::ST_READ;
      vts_pkg::ST_READ: begin
        if (k_q == 4'd8) begin
          state_d = vts_pkg::ST_MUL;
        end
      end
      vts_pkg::ST_MUL:  state_d = vts_pkg::ST_ADD;
      vts_pkg::ST_ADD: begin
        state_d = (n_q == 4'd2) ? vts_pkg::ST_IDLE : vts_pkg::ST_MUL;
      end
      default: state_d = vts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vts_pkg::ST_IDLE;
      done_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pts_q[i] <= vts_pkg::POINTS_RESET;
      end
    end else begin
      state_q <= state_d;
      done_q  <= (accept && ((operation_i == vts_pkg::OP_WRITE) || pos_bad)) ||
                 ((state_q == vts_pkg::ST_ADD) && (n_q == 4'd2));
      if (cfg_we_i) begin
        case (cfg_index_i)
          vts_pkg::REG_POINTS_X: pts_q[0] <= cfg_data_i;
          vts_pkg::REG_POINTS_Y: pts_q[1] <= cfg_data_i;
          vts_pkg::REG_POINTS_Z: pts_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx] <= SB'(sample_value_i);
    end
    rdata_q  <= mem_q[mem_idx];
    rd_oob_q <= !corner_ok;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      vts_pkg::ST_IDLE: begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        axis_q   <= 2'd0;
        k_q      <= 4'd0;
        n_q      <= 4'd8;
        if (accept) begin
          value_q <= '0;
          oor_q   <= (operation_i == vts_pkg::OP_SAMPLE) && pos_bad;
        end
      end
      vts_pkg::ST_LOC: begin
        cell_q[axis_q] <= c_clamp;
        frac_q[axis_q] <= 17'(scaled - (SW'(c_clamp) << vts_pkg::FRAC_BITS));
        axis_q         <= axis_q + 2'd1;
        if (axis_q == 2'd0) begin
          nxny_q <= (2*PW)'(np[0]) * (2*PW)'(np[1]);
        end
      end
      vts_pkg::ST_OFFS: begin
        yoff_q <= LW'(cell_q[1]) * LW'(np[0]);
        zoff_q <= LW'(cell_q[2]) * LW'(nxny_q);
      end
      vts_pkg::ST_BASE: begin
        base_q <= LW'(cell_q[0]) + yoff_q + zoff_q;
      end
      vts_pkg::ST_READ: begin
        k_q <= k_q + 4'd1;
        if (k_q != 4'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_q[i] <= v_q[i+1];
          end
          v_q[7] <= rd_oob_q ? '0 : rdata_q;
        end
      end
      vts_pkg::ST_MUL: begin
        a_q    <= v_q[0];
        prod_q <= PRW'(diff) * PRW'($signed({1'b0, f_sel}));
      end
      vts_pkg::ST_ADD: begin
        for (int i = 0; i < 6; i++) begin
          v_q[i] <= (3'(i) == ins_idx) ? blend_r : v_q[i+2];
        end
        if (ins_idx == 3'd6) begin
          v_q[6] <= blend_r;
        end
        n_q <= n_q - 4'd1;
        if (n_q == 4'd2) begin
          value_q <= 16'(blend_r);
          oor_q   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign done_o               = done_q;
  assign interpolated_value_o = value_q;
  assign pos_err_o            = oor_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while a sample is in flight");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pos_err_o) |-> (interpolated_value_o == 16'd0))
    else $error("out-of-range result carries a nonzero value");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == vts_pkg::OP_WRITE)) |=>
      (done_o && !pos_err_o && (interpolated_value_o == 16'd0)))
    else $error("write transfer without a clean result");

  a_last_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == vts_pkg::ST_ADD) && (n_q == 4'd2)) |=> (done_o && !busy_o))
    else $error("last blend did not produce a result");

  a_read_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == vts_pkg::ST_READ) && (k_q == 4'd8)) |=> (state_q == vts_pkg::ST_MUL))
    else $error("corner fetch did not hand off to blending");

endmodule

`default_nettype wire
